/* hw/rtl/top_node_edge_relabel_defines.svh */
// Assertion macros shared by the RTL of the edge relabeling block.
// Depends on nothing; the asserting module must have clk and rst_n in scope.
`ifndef TOP_NODE_EDGE_RELABEL_DEFINES_SVH
`define TOP_NODE_EDGE_RELABEL_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define TNER_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define TNER_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TNER_ASSERT(label, prop, msg)
`define TNER_ASSERT_NEVER(label, cond, msg)
`endif
`endif

/* hw/rtl/tner_pkg.sv */
// Types and constants of the edge relabeling block.
// Depends on nothing; used by every RTL module.
package tner_pkg;

    localparam int NODE_W      = 32;
    localparam int COUNT_W     = 5;
    localparam int INDEX_W     = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_FWD  = 2'd1,
        FUNC_REV  = 2'd2
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NODE_LIMIT = 1'b0,
        CFG_TOP_COUNT  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        func_t              func;
        logic [INDEX_W-1:0] entry_index;
        logic [NODE_W-1:0]  entry_node;
        logic [NODE_W-1:0]  edge_u;
        logic [NODE_W-1:0]  edge_v;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] low_node;
        logic [NODE_W-1:0] high_node;
    } rsp_t;

    // Match summary handed from the compare stage to the resolve stage.
    typedef struct packed {
        logic rev;
        logic hit_u;
        logic hit_v;
    } sel_t;

endpackage

/* hw/rtl/tner_stream_if.sv */
// Valid/ready stream interface carrying one payload per transaction.
// Depends on nothing; the payload type is given per instance.
interface tner_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tner_match.sv */
// Compare stage: matches both endpoints and every fresh id against the table.
// Depends on tner_pkg.
module tner_match #(
    parameter int  TOP_ENTRIES = 16,
    localparam int SLOT_W = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1,
    localparam int CNT_W  = $clog2(TOP_ENTRIES + 1)
) (
    input  tner_pkg::func_t            func,
    input  logic [CNT_W-1:0]           used_count,
    input  logic [tner_pkg::NODE_W-1:0] base,
    input  logic [tner_pkg::NODE_W-1:0] entries [TOP_ENTRIES],
    input  logic [tner_pkg::NODE_W-1:0] edge_u,
    input  logic [tner_pkg::NODE_W-1:0] edge_v,
    output tner_pkg::sel_t             sel,
    output logic [SLOT_W-1:0]          start_u,
    output logic [SLOT_W-1:0]          start_v,
    output logic [SLOT_W-1:0]          succ [TOP_ENTRIES]
);
    import tner_pkg::*;

    logic [NODE_W-1:0]      fresh [TOP_ENTRIES];
    logic [TOP_ENTRIES-1:0] in_use;
    // eq[a][b] is set when entry b equals the fresh id of slot a.
    logic [TOP_ENTRIES-1:0] eq [TOP_ENTRIES];
    logic                   rev;
    logic                   hit_u;
    logic                   hit_v;

    assign rev = (func == FUNC_REV);

    for (genvar a = 0; a < TOP_ENTRIES; a++) begin : g_slot
        assign fresh[a]  = base - NODE_W'(a);
        assign in_use[a] = (CNT_W'(a) < used_count);
        for (genvar b = 0; b < TOP_ENTRIES; b++) begin : g_pair
            assign eq[a][b] = in_use[a] && in_use[b] && (entries[b] == fresh[a]);
        end
    end

    // Slot that takes over once a slot has rewritten the value: the first later
    // slot that matches the rewritten value, or the slot itself when none does.
    always_comb
    begin
        for (int k = 0; k < TOP_ENTRIES; k++)
        begin
            succ[k] = SLOT_W'(k);
            for (int j = TOP_ENTRIES - 1; j > k; j--)
            begin
                if (rev ? eq[j][k] : eq[k][j])
                begin
                    succ[k] = SLOT_W'(j);
                end
            end
        end
    end

    // First slot that the original endpoint value hits.
    always_comb
    begin
        hit_u   = 1'b0;
        hit_v   = 1'b0;
        start_u = '0;
        start_v = '0;
        for (int k = TOP_ENTRIES - 1; k >= 0; k--)
        begin
            if (in_use[k] && (rev ? (edge_u == fresh[k]) : (edge_u == entries[k])))
            begin
                hit_u   = 1'b1;
                start_u = SLOT_W'(k);
            end
            if (in_use[k] && (rev ? (edge_v == fresh[k]) : (edge_v == entries[k])))
            begin
                hit_v   = 1'b1;
                start_v = SLOT_W'(k);
            end
        end
    end

    always_comb
    begin
        sel.rev   = rev;
        sel.hit_u = hit_u;
        sel.hit_v = hit_v;
    end

endmodule

/* hw/rtl/tner_resolve.sv */
// Resolve stage: follows the slot chain by pointer doubling, forms the new
// labels and orders the two endpoints. Depends on tner_pkg.
module tner_resolve #(
    parameter int  TOP_ENTRIES = 16,
    localparam int SLOT_W = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1
) (
    input  tner_pkg::sel_t              sel,
    input  logic [SLOT_W-1:0]           start_u,
    input  logic [SLOT_W-1:0]           start_v,
    input  logic [SLOT_W-1:0]           succ [TOP_ENTRIES],
    input  logic [tner_pkg::NODE_W-1:0] entries [TOP_ENTRIES],
    input  logic [tner_pkg::NODE_W-1:0] base,
    input  logic [tner_pkg::NODE_W-1:0] edge_u,
    input  logic [tner_pkg::NODE_W-1:0] edge_v,
    output logic [tner_pkg::NODE_W-1:0] low_node,
    output logic [tner_pkg::NODE_W-1:0] high_node
);
    import tner_pkg::*;

    // jump[l][k] is the slot reached from slot k after 2**l chain steps.
    logic [SLOT_W-1:0] jump [SLOT_W+1][TOP_ENTRIES];
    logic [SLOT_W-1:0] last_u;
    logic [SLOT_W-1:0] last_v;
    logic [NODE_W-1:0] val_u;
    logic [NODE_W-1:0] val_v;

    for (genvar k = 0; k < TOP_ENTRIES; k++) begin : g_base
        assign jump[0][k] = succ[k];
    end

    for (genvar l = 0; l < SLOT_W; l++) begin : g_level
        for (genvar k = 0; k < TOP_ENTRIES; k++) begin : g_slot
            assign jump[l+1][k] = jump[l][jump[l][k]];
        end
    end

    assign last_u = jump[SLOT_W][start_u];
    assign last_v = jump[SLOT_W][start_v];

    always_comb
    begin
        val_u = edge_u;
        val_v = edge_v;
        if (sel.hit_u)
        begin
            val_u = sel.rev ? entries[last_u] : (base - NODE_W'(last_u));
        end
        if (sel.hit_v)
        begin
            val_v = sel.rev ? entries[last_v] : (base - NODE_W'(last_v));
        end
    end

    always_comb
    begin
        if (val_u > val_v)
        begin
            low_node  = val_v;
            high_node = val_u;
        end
        else
        begin
            low_node  = val_u;
            high_node = val_v;
        end
    end

endmodule

/* hw/rtl/top_node_edge_relabel.sv */
// Top level of the edge relabeling block: configuration, frequent-node table
// and the two-stage relabel pipeline. Depends on tner_pkg, tner_stream_if,
// tner_match, tner_resolve and top_node_edge_relabel_defines.svh.
//
// Usage: items arrive on the req stream, one transaction each. A load item
// writes one table slot; a forward or reverse remap item carries one edge and
// produces exactly one transaction on the rsp stream holding the relabeled
// endpoints, smaller first. Loads and unused selector codes produce nothing.
// Configuration (node limit at index 0, top_count at index 1) is written
// through cfg_we, cfg_index and cfg_data while no item is in flight; it takes
// effect on the next cycle.
// A remap passes through the input register, the match register and the output
// register before its result shows on rsp.
// Throughput: one item per cycle unless rsp stalls, set by the single compare
// stage and the single resolve stage, each taking a new item every cycle.
// Reset clears the pipeline valid flags and the configuration to zero; the
// table keeps whatever it held and each slot must be loaded before use.
// When the receiver stalls rsp, the whole pipeline holds and req.ready drops
// in the same cycle; table writes happen only as the pipeline advances.
`include "top_node_edge_relabel_defines.svh"

module top_node_edge_relabel #(
    parameter int TOP_ENTRIES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tner_stream_if.sink                     req,
    tner_stream_if.source                   rsp,
    input  logic                            cfg_we,
    input  logic [tner_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tner_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tner_pkg::*;

    localparam int SLOT_W = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TOP_ENTRIES + 1);

    // Configuration. The fresh-id base node_limit + count is kept ready so
    // that the compare stage needs only one subtract per slot.
    logic [NODE_W-1:0] node_limit_reg;
    logic [NODE_W-1:0] node_limit_next;
    logic [CNT_W-1:0]  used_count_reg;
    logic [CNT_W-1:0]  used_count_next;
    logic [NODE_W-1:0] base_reg;
    logic [NODE_W-1:0] base_next;

    // Frequent-node table, written by load items as they leave the input stage.
    logic [NODE_W-1:0] entry_reg [TOP_ENTRIES];

    // Input stage.
    logic              s1_valid_reg;
    req_t              s1_req_reg;

    // Match stage.
    logic              s2_valid_reg;
    sel_t              s2_sel_reg;
    logic [SLOT_W-1:0] s2_start_u_reg;
    logic [SLOT_W-1:0] s2_start_v_reg;
    logic [SLOT_W-1:0] s2_succ_reg [TOP_ENTRIES];
    logic [NODE_W-1:0] s2_u_reg;
    logic [NODE_W-1:0] s2_v_reg;

    // Output stage.
    logic              out_valid_reg;
    rsp_t              out_data_reg;

    logic              advance;
    logic              load_fire;
    logic              s1_remap;
    sel_t              match_sel;
    logic [SLOT_W-1:0] match_start_u;
    logic [SLOT_W-1:0] match_start_v;
    logic [SLOT_W-1:0] match_succ [TOP_ENTRIES];
    logic [NODE_W-1:0] res_low;
    logic [NODE_W-1:0] res_high;

    // Effective count: values above the table size use the whole table.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return (wide > 32'(TOP_ENTRIES)) ? CNT_W'(TOP_ENTRIES) : CNT_W'(wide);
    endfunction

    always_comb
    begin
        node_limit_next = node_limit_reg;
        used_count_next = used_count_reg;
        base_next       = base_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_NODE_LIMIT:
                begin
                    node_limit_next = cfg_data[NODE_W-1:0];
                    base_next       = cfg_data[NODE_W-1:0] + NODE_W'(used_count_reg);
                end
                CFG_TOP_COUNT:
                begin
                    used_count_next = clamp_count(cfg_data[COUNT_W-1:0]);
                    base_next       = node_limit_reg
                                    + NODE_W'(clamp_count(cfg_data[COUNT_W-1:0]));
                end
                default:
                begin
                    node_limit_next = node_limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_limit_reg <= '0;
            used_count_reg <= '0;
            base_reg       <= '0;
        end
        else
        begin
            node_limit_reg <= node_limit_next;
            used_count_reg <= used_count_next;
            base_reg       <= base_next;
        end
    end

    // The pipeline moves as one; it holds only while a result waits on rsp.
    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = advance;
    assign s1_remap  = (s1_req_reg.func == FUNC_FWD) || (s1_req_reg.func == FUNC_REV);
    assign load_fire = advance && s1_valid_reg && (s1_req_reg.func == FUNC_LOAD);

    // A load lands in the table as it leaves the input stage, so the item right
    // behind it sees it, and the item ahead of it in the match stage does not.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < TOP_ENTRIES; k++)
        begin
            if (load_fire && (32'(s1_req_reg.entry_index) == 32'(k)))
            begin
                entry_reg[k] <= s1_req_reg.entry_node;
            end
        end
    end

    tner_match #(
        .TOP_ENTRIES (TOP_ENTRIES)
    ) u_match (
        .func       (s1_req_reg.func),
        .used_count (used_count_reg),
        .base       (base_reg),
        .entries    (entry_reg),
        .edge_u     (s1_req_reg.edge_u),
        .edge_v     (s1_req_reg.edge_v),
        .sel        (match_sel),
        .start_u    (match_start_u),
        .start_v    (match_start_v),
        .succ       (match_succ)
    );

    tner_resolve #(
        .TOP_ENTRIES (TOP_ENTRIES)
    ) u_resolve (
        .sel       (s2_sel_reg),
        .start_u   (s2_start_u_reg),
        .start_v   (s2_start_v_reg),
        .succ      (s2_succ_reg),
        .entries   (entry_reg),
        .base      (base_reg),
        .edge_u    (s2_u_reg),
        .edge_v    (s2_v_reg),
        .low_node  (res_low),
        .high_node (res_high)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= req.valid;
            s2_valid_reg  <= s1_valid_reg && s1_remap;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_req_reg     <= req.data;
            s2_sel_reg     <= match_sel;
            s2_start_u_reg <= match_start_u;
            s2_start_v_reg <= match_start_v;
            s2_succ_reg    <= match_succ;
            s2_u_reg       <= s1_req_reg.edge_u;
            s2_v_reg       <= s1_req_reg.edge_v;
            out_data_reg.low_node  <= res_low;
            out_data_reg.high_node <= res_high;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // A remap that flows through the pipeline without a stall must come out as a result.
    `TNER_ASSERT(a_remap_reaches_output,
        req.valid && req.ready
        && ((req.data.func == FUNC_FWD) || (req.data.func == FUNC_REV))
        ##1 advance ##1 advance |=> out_valid_reg,
        "remap transaction lost in the pipeline")
    // A load never turns into a result.
    `TNER_ASSERT(a_load_gives_no_result,
        advance && s1_valid_reg && (s1_req_reg.func == FUNC_LOAD) |=> !s2_valid_reg,
        "load produced a result")
    // The u endpoint's chain starts only at slots inside the effective count.
    `TNER_ASSERT(a_start_in_range,
        s2_valid_reg && s2_sel_reg.hit_u |-> 32'(s2_start_u_reg) < 32'(used_count_reg),
        "endpoint matched an unused slot")
    // Results leave ordered, smaller endpoint first.
    `TNER_ASSERT_NEVER(a_result_ordered,
        rsp.valid && (rsp.data.low_node > rsp.data.high_node),
        "result endpoints out of order")

endmodule
